// ----- rtl/infinite_reverse_projection_setup_top_macros.svh -----
// Assertion macros shared by the projection setup block
`ifndef INFINITE_REVERSE_PROJECTION_SETUP_TOP_MACROS_SVH
`define INFINITE_REVERSE_PROJECTION_SETUP_TOP_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define IRPS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that the consequent holds in the cycle after the antecedent
`define IRPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/irps_pkg.sv -----
`default_nettype none

package irps_pkg;

   localparam int ANGLE_FRAC_BITS_DEF  = 14;
   localparam int RESULT_FRAC_BITS_DEF = 16;

   localparam int LANES        = 4;
   localparam int ANGLE_W      = 16;
   localparam int NEAR_W       = 31;
   localparam int RES_W        = 32;
   localparam int Q_BITS       = 30;
   localparam int CORDIC_STEPS = 30;
   localparam int XY_W         = 34;
   localparam int Z_W          = 33;
   localparam int TAN_QUOT_W   = 45;
   localparam int TAN_W        = 47;
   localparam int SPAN_W       = 48;
   localparam int MAG_W        = 47;
   localparam int RES_QUOT_W   = 33;

   localparam logic signed [Z_W-1:0]  HALF_PI_Q30 = 33'sd1686629713;
   localparam logic signed [XY_W-1:0] ONE_Q30     = 34'sd1073741824;
   localparam logic [MAG_W-1:0]       TWO_Q30     = 47'd2147483648;
   localparam logic [TAN_W-1:0]       TAN_LIMIT   = 47'd35184372088832;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_DEGEN = 2'd1,
      STATUS_SAT   = 2'd2
   } status_type;

   // Sideband that rides along the CORDIC lanes
   typedef struct packed {
      logic [NEAR_W-1:0] near;
      logic              y_down;
   } cordic_side_type;

   // Sideband that rides along the tangent divider
   typedef struct packed {
      logic [NEAR_W-1:0] near;
      logic              y_down;
      logic [LANES-1:0]  y_neg;
      logic [LANES-1:0]  x_bad;
   } tan_side_type;

   // Sideband that rides along the result divider
   typedef struct packed {
      logic [NEAR_W-1:0] near;
      logic              sat;
      logic [LANES-1:0]  neg;
      logic              degen_x;
      logic              degen_y;
   } res_side_type;

   // Arctangent of 2^-i in Q2.30
   function automatic logic signed [Z_W-1:0] atan_entry(input int idx);
      logic signed [Z_W-1:0] val;
      case (idx)
         0:  val = 33'sd843314856;
         1:  val = 33'sd497837829;
         2:  val = 33'sd263043836;
         3:  val = 33'sd133525158;
         4:  val = 33'sd66890614;
         5:  val = 33'sd33476955;
         6:  val = 33'sd16775850;
         7:  val = 33'sd8388437;
         8:  val = 33'sd4194282;
         9:  val = 33'sd2097149;
         10: val = 33'sd1048575;
         11: val = 33'sd524287;
         12: val = 33'sd262143;
         13: val = 33'sd131071;
         14: val = 33'sd65535;
         15: val = 33'sd32767;
         16: val = 33'sd16383;
         17: val = 33'sd8191;
         18: val = 33'sd4095;
         19: val = 33'sd2047;
         20: val = 33'sd1023;
         21: val = 33'sd511;
         22: val = 33'sd255;
         23: val = 33'sd127;
         24: val = 33'sd63;
         25: val = 33'sd31;
         26: val = 33'sd15;
         27: val = 33'sd8;
         28: val = 33'sd4;
         29: val = 33'sd2;
         default: val = '0;
      endcase
      return val;
   endfunction

   // Magnitude of a signed span value
   function automatic logic [MAG_W-1:0] span_mag(input logic signed [SPAN_W-1:0] v);
      logic signed [SPAN_W-1:0] n;
      n = -v;
      return (v < 0) ? n[MAG_W-1:0] : v[MAG_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ----- rtl/infinite_reverse_projection_setup_top.sv -----
// Channel   Ports                        Transfer
// request   start, busy, req_*           start high and busy low at a rising edge
// response  rsp_valid, rsp_*             one-cycle strobe, always taken
// config    csr_valid, csr_ready, csr_*  valid and ready high at a rising edge
//
// A request reaches its response through 31 CORDIC stages, 46 tangent divider stages,
// the tangent clip register, the span register, 34 result divider stages and the output register.
// A new request is taken every cycle while busy is low; busy is high only during and just after reset.
// Reset clears every valid bit, so nothing in flight survives it, and sets y_down.
// The receiver cannot stall, so the pipeline never holds.
`default_nettype none

`include "infinite_reverse_projection_setup_top_macros.svh"

module infinite_reverse_projection_setup_top import irps_pkg::*; #(
   parameter int ANGLE_FRAC_BITS  = ANGLE_FRAC_BITS_DEF,
   parameter int RESULT_FRAC_BITS = RESULT_FRAC_BITS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire logic signed [ANGLE_W-1:0] req_left_angle,
   input  wire logic signed [ANGLE_W-1:0] req_right_angle,
   input  wire logic signed [ANGLE_W-1:0] req_down_angle,
   input  wire logic signed [ANGLE_W-1:0] req_up_angle,
   input  wire logic [NEAR_W-1:0]         req_near_distance,
   output logic                           rsp_valid,
   output logic signed [RES_W-1:0]        rsp_scale_x,
   output logic signed [RES_W-1:0]        rsp_scale_y,
   output logic signed [RES_W-1:0]        rsp_offset_x,
   output logic signed [RES_W-1:0]        rsp_offset_y,
   output logic [NEAR_W-1:0]              rsp_depth_term,
   output logic [1:0]                     rsp_status,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic                      csr_y_down
);

   localparam int RES_NUM_W = MAG_W + RESULT_FRAC_BITS;
   localparam int TAN_NUM_W = XY_W + Q_BITS;
   localparam int LATENCY   = CORDIC_STEPS + 1 + TAN_QUOT_W + 1 + 2 + RES_QUOT_W + 1 + 1;

   // Configuration register and handshake
   logic y_down_ff;
   logic busy_ff;
   logic accept;

   assign csr_ready = 1'b1;
   assign busy      = busy_ff;
   assign accept    = start && !busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         y_down_ff <= 1'b1;
         busy_ff   <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            y_down_ff <= csr_y_down;
         end
      end
   end

   // Rotate the edge angles: lanes left, right, down, up
   logic [LANES-1:0][ANGLE_W-1:0] angles;
   cordic_side_type               cor_side_in;
   cordic_side_type               cor_side_out;
   logic                          cor_valid;
   logic [LANES-1:0][XY_W-1:0]    cor_x;
   logic [LANES-1:0][XY_W-1:0]    cor_y;

   assign angles[0]          = req_left_angle;
   assign angles[1]          = req_right_angle;
   assign angles[2]          = req_down_angle;
   assign angles[3]          = req_up_angle;
   assign cor_side_in.near   = req_near_distance;
   assign cor_side_in.y_down = y_down_ff;

   irps_cordic #(
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
      .SIDE_W          ($bits(cordic_side_type))
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_angle  (angles),
      .in_side   (cor_side_in),
      .out_valid (cor_valid),
      .out_x     (cor_x),
      .out_y     (cor_y),
      .out_side  (cor_side_out)
   );

   // Divide y by x for each tangent; a large quotient comes back as overflow
   logic [LANES-1:0][TAN_NUM_W-1:0] tan_num;
   logic [LANES-1:0][XY_W-1:0]      tan_den;
   tan_side_type                    tan_side_in;
   tan_side_type                    tan_side_out;
   logic                            tan_valid;
   logic [LANES-1:0][TAN_QUOT_W-1:0] tan_quot;
   logic [LANES-1:0]                tan_ovf;

   for (genvar l = 0; l < LANES; l++) begin : g_tan_in
      logic signed [XY_W-1:0] xs;
      logic signed [XY_W-1:0] ys;
      logic [XY_W-1:0]        ay;
      assign xs = signed'(cor_x[l]);
      assign ys = signed'(cor_y[l]);
      assign ay = (ys < 0) ? XY_W'(-ys) : XY_W'(ys);
      assign tan_num[l]        = {ay, {Q_BITS{1'b0}}};
      assign tan_den[l]        = cor_x[l];
      assign tan_side_in.y_neg[l] = ys < 0;
      assign tan_side_in.x_bad[l] = xs <= 0;
   end
   assign tan_side_in.near   = cor_side_out.near;
   assign tan_side_in.y_down = cor_side_out.y_down;

   irps_div #(
      .NUM_W  (TAN_NUM_W),
      .DEN_W  (XY_W),
      .QUOT_W (TAN_QUOT_W),
      .SIDE_W ($bits(tan_side_type))
   ) u_tan_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cor_valid),
      .in_num    (tan_num),
      .in_den    (tan_den),
      .in_side   (tan_side_in),
      .out_valid (tan_valid),
      .out_quot  (tan_quot),
      .out_ovf   (tan_ovf),
      .out_side  (tan_side_out)
   );

   // Sign the tangents and clip them at the limit
   logic signed [TAN_W-1:0] tan_ff [LANES];
   logic signed [TAN_W-1:0] tan_in [LANES];
   logic [LANES-1:0]        tsat;
   logic                    tvalid_ff;
   logic                    tsat_ff;
   logic                    tydown_ff;
   logic [NEAR_W-1:0]       tnear_ff;

   for (genvar l = 0; l < LANES; l++) begin : g_tan
      logic [TAN_W-1:0] mag;
      assign tsat[l]   = tan_side_out.x_bad[l] || tan_ovf[l];
      assign mag       = tsat[l] ? TAN_LIMIT : TAN_W'(tan_quot[l]);
      assign tan_in[l] = tan_side_out.y_neg[l] ? signed'(~mag + 1'b1) : signed'(mag);
   end

   always_ff @(posedge clock) begin
      tan_ff    <= tan_in;
      tsat_ff   <= |tsat;
      tydown_ff <= tan_side_out.y_down;
      tnear_ff  <= tan_side_out.near;
      if (reset) begin
         tvalid_ff <= 1'b0;
      end else begin
         tvalid_ff <= tan_valid;
      end
   end

   // Form spans and tangent sums
   logic signed [SPAN_W-1:0] w_ff;
   logic signed [SPAN_W-1:0] h_ff;
   logic signed [SPAN_W-1:0] sumx_ff;
   logic signed [SPAN_W-1:0] sumy_ff;
   logic                     svalid_ff;
   logic                     ssat_ff;
   logic [NEAR_W-1:0]        snear_ff;
   logic signed [SPAN_W-1:0] tl;
   logic signed [SPAN_W-1:0] tr;
   logic signed [SPAN_W-1:0] td;
   logic signed [SPAN_W-1:0] tu;

   assign tl = SPAN_W'(tan_ff[0]);
   assign tr = SPAN_W'(tan_ff[1]);
   assign td = SPAN_W'(tan_ff[2]);
   assign tu = SPAN_W'(tan_ff[3]);

   always_ff @(posedge clock) begin
      w_ff     <= tr - tl;
      h_ff     <= tydown_ff ? (td - tu) : (tu - td);
      sumx_ff  <= tr + tl;
      sumy_ff  <= tu + td;
      ssat_ff  <= tsat_ff;
      snear_ff <= tnear_ff;
      if (reset) begin
         svalid_ff <= 1'b0;
      end else begin
         svalid_ff <= tvalid_ff;
      end
   end

   // Divide numerators by spans: lanes scale x, offset x, scale y, offset y
   logic [LANES-1:0][RES_NUM_W-1:0]  res_num;
   logic [LANES-1:0][MAG_W-1:0]      res_den;
   logic [LANES-1:0][MAG_W-1:0]      res_mag;
   res_side_type                     res_side_in;
   res_side_type                     res_side_out;
   logic                             res_valid;
   logic [LANES-1:0][RES_QUOT_W-1:0] res_quot;
   logic [LANES-1:0]                 res_ovf;

   assign res_mag[0] = TWO_Q30;
   assign res_mag[1] = span_mag(sumx_ff);
   assign res_mag[2] = TWO_Q30;
   assign res_mag[3] = span_mag(sumy_ff);
   assign res_den[0] = span_mag(w_ff);
   assign res_den[1] = span_mag(w_ff);
   assign res_den[2] = span_mag(h_ff);
   assign res_den[3] = span_mag(h_ff);

   for (genvar l = 0; l < LANES; l++) begin : g_res_in
      assign res_num[l] = {res_mag[l], {RESULT_FRAC_BITS{1'b0}}};
   end

   assign res_side_in.near    = snear_ff;
   assign res_side_in.sat     = ssat_ff;
   assign res_side_in.neg[0]  = w_ff < 0;
   assign res_side_in.neg[1]  = (sumx_ff < 0) != (w_ff < 0);
   assign res_side_in.neg[2]  = h_ff < 0;
   assign res_side_in.neg[3]  = (sumy_ff < 0) != (h_ff < 0);
   assign res_side_in.degen_x = w_ff == '0;
   assign res_side_in.degen_y = h_ff == '0;

   irps_div #(
      .NUM_W  (RES_NUM_W),
      .DEN_W  (MAG_W),
      .QUOT_W (RES_QUOT_W),
      .SIDE_W ($bits(res_side_type))
   ) u_res_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (svalid_ff),
      .in_num    (res_num),
      .in_den    (res_den),
      .in_side   (res_side_in),
      .out_valid (res_valid),
      .out_quot  (res_quot),
      .out_ovf   (res_ovf),
      .out_side  (res_side_out)
   );

   // Saturate and sign each result, drop degenerate axes
   logic signed [RES_W-1:0] val [LANES];
   logic [LANES-1:0]        lsat;
   logic [LANES-1:0]        lzero;

   assign lzero[0] = res_side_out.degen_x;
   assign lzero[1] = res_side_out.degen_x;
   assign lzero[2] = res_side_out.degen_y;
   assign lzero[3] = res_side_out.degen_y;

   for (genvar l = 0; l < LANES; l++) begin : g_fin
      logic [RES_QUOT_W-1:0] q;
      logic [RES_QUOT_W-1:0] nq;
      logic                  big_neg;
      logic                  big_pos;
      assign q       = res_quot[l];
      assign nq      = ~q + 1'b1;
      assign big_neg = res_ovf[l] || (q > {2'b01, {(RES_QUOT_W-2){1'b0}}});
      assign big_pos = res_ovf[l] || q[RES_QUOT_W-1] || q[RES_QUOT_W-2];
      always_comb begin
         if (lzero[l]) begin
            val[l]  = '0;
            lsat[l] = 1'b0;
         end else if (res_side_out.neg[l]) begin
            lsat[l] = big_neg;
            val[l]  = big_neg ? signed'({1'b1, {(RES_W-1){1'b0}}}) : signed'(nq[RES_W-1:0]);
         end else begin
            lsat[l] = big_pos;
            val[l]  = big_pos ? signed'({1'b0, {(RES_W-1){1'b1}}}) : signed'(q[RES_W-1:0]);
         end
      end
   end

   status_type status_in;
   always_comb begin
      if (res_side_out.degen_x || res_side_out.degen_y) begin
         status_in = STATUS_DEGEN;
      end else if (res_side_out.sat || (|lsat)) begin
         status_in = STATUS_SAT;
      end else begin
         status_in = STATUS_OK;
      end
   end

   // Output register
   logic                    out_valid_ff;
   logic signed [RES_W-1:0] sx_ff;
   logic signed [RES_W-1:0] ox_ff;
   logic signed [RES_W-1:0] sy_ff;
   logic signed [RES_W-1:0] oy_ff;
   logic [NEAR_W-1:0]       depth_ff;
   status_type              status_ff;

   always_ff @(posedge clock) begin
      sx_ff     <= val[0];
      ox_ff     <= val[1];
      sy_ff     <= val[2];
      oy_ff     <= val[3];
      depth_ff  <= res_side_out.near;
      status_ff <= status_in;
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= res_valid;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_scale_x    = sx_ff;
   assign rsp_offset_x   = ox_ff;
   assign rsp_scale_y    = sy_ff;
   assign rsp_offset_y   = oy_ff;
   assign rsp_depth_term = depth_ff;
   assign rsp_status     = status_ff;

   // Checks
   `IRPS_ASSERT_IMP(a_latency, clock, reset, start && !busy, ##LATENCY rsp_valid, "response missing")
   `IRPS_ASSERT_IMP(a_origin, clock, reset, rsp_valid, $past(start && !busy, LATENCY), "response without request")
   `IRPS_ASSERT_IMP(a_degen, clock, reset, rsp_valid && rsp_status == STATUS_DEGEN, (rsp_scale_x == 0 && rsp_offset_x == 0) || (rsp_scale_y == 0 && rsp_offset_y == 0), "degenerate axis not cleared")
   `IRPS_ASSERT_NEXT(a_csr, clock, reset, csr_valid && csr_ready, y_down_ff == $past(csr_y_down), "config write lost")

endmodule

`default_nettype wire

// ----- rtl/irps_cordic.sv -----
`default_nettype none

module irps_cordic import irps_pkg::*; #(
   parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
   parameter int SIDE_W          = 1
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             in_valid,
   input  wire logic [LANES-1:0][ANGLE_W-1:0]    in_angle,
   input  wire logic [SIDE_W-1:0]                in_side,
   output logic                                  out_valid,
   output logic [LANES-1:0][XY_W-1:0]            out_x,
   output logic [LANES-1:0][XY_W-1:0]            out_y,
   output logic [SIDE_W-1:0]                     out_side
);

   localparam int SHIFT  = Q_BITS - ANGLE_FRAC_BITS;
   localparam int WIDE_W = ANGLE_W + SHIFT;
   localparam int CMP_W  = (WIDE_W > Z_W) ? WIDE_W + 1 : Z_W + 1;

   logic signed [XY_W-1:0] x_ff [CORDIC_STEPS+1][LANES];
   logic signed [XY_W-1:0] x_in [CORDIC_STEPS+1][LANES];
   logic signed [XY_W-1:0] y_ff [CORDIC_STEPS+1][LANES];
   logic signed [XY_W-1:0] y_in [CORDIC_STEPS+1][LANES];
   logic signed [Z_W-1:0]  z_ff [CORDIC_STEPS+1][LANES];
   logic signed [Z_W-1:0]  z_in [CORDIC_STEPS+1][LANES];
   logic [CORDIC_STEPS:0]  valid_ff;
   logic [CORDIC_STEPS:0]  valid_in;
   logic [SIDE_W-1:0]      side_ff [CORDIC_STEPS+1];
   logic [SIDE_W-1:0]      side_in [CORDIC_STEPS+1];

   // Widen each angle to Q2.30 and clamp to a quarter turn
   for (genvar l = 0; l < LANES; l++) begin : g_entry
      logic signed [WIDE_W-1:0] wide;
      logic signed [CMP_W-1:0]  ext;
      assign wide = WIDE_W'(signed'(in_angle[l])) <<< SHIFT;
      assign ext  = CMP_W'(wide);
      always_comb begin
         if (ext > CMP_W'(HALF_PI_Q30)) begin
            z_in[0][l] = HALF_PI_Q30;
         end else if (ext < -CMP_W'(HALF_PI_Q30)) begin
            z_in[0][l] = -HALF_PI_Q30;
         end else begin
            z_in[0][l] = ext[Z_W-1:0];
         end
      end
      assign x_in[0][l] = ONE_Q30;
      assign y_in[0][l] = '0;
   end
   assign valid_in[0] = in_valid;
   assign side_in[0]  = in_side;

   // One micro-rotation per stage
   for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_step
      for (genvar l = 0; l < LANES; l++) begin : g_lane
         always_comb begin
            if (z_ff[s][l] >= 0) begin
               x_in[s+1][l] = x_ff[s][l] - (y_ff[s][l] >>> s);
               y_in[s+1][l] = y_ff[s][l] + (x_ff[s][l] >>> s);
               z_in[s+1][l] = z_ff[s][l] - atan_entry(s);
            end else begin
               x_in[s+1][l] = x_ff[s][l] + (y_ff[s][l] >>> s);
               y_in[s+1][l] = y_ff[s][l] - (x_ff[s][l] >>> s);
               z_in[s+1][l] = z_ff[s][l] + atan_entry(s);
            end
         end
      end
      assign valid_in[s+1] = valid_ff[s];
      assign side_in[s+1]  = side_ff[s];
   end

   // Advance the stage registers
   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      side_ff <= side_in;
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   for (genvar l = 0; l < LANES; l++) begin : g_out
      assign out_x[l] = x_ff[CORDIC_STEPS][l];
      assign out_y[l] = y_ff[CORDIC_STEPS][l];
   end
   assign out_valid = valid_ff[CORDIC_STEPS];
   assign out_side  = side_ff[CORDIC_STEPS];

endmodule

`default_nettype wire

// ----- rtl/irps_div.sv -----
`default_nettype none

module irps_div import irps_pkg::*; #(
   parameter int NUM_W  = 64,
   parameter int DEN_W  = 34,
   parameter int QUOT_W = 45,
   parameter int SIDE_W = 1
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           in_valid,
   input  wire logic [LANES-1:0][NUM_W-1:0]    in_num,
   input  wire logic [LANES-1:0][DEN_W-1:0]    in_den,
   input  wire logic [SIDE_W-1:0]              in_side,
   output logic                                out_valid,
   output logic [LANES-1:0][QUOT_W-1:0]        out_quot,
   output logic [LANES-1:0]                    out_ovf,
   output logic [SIDE_W-1:0]                   out_side
);

   localparam int HEAD_W = NUM_W - QUOT_W;
   localparam int CMP_W  = (HEAD_W > DEN_W) ? HEAD_W : DEN_W;

   // rem: partial remainder; work: numerator bits out at the top, quotient bits in below
   logic [DEN_W-1:0]  rem_ff  [QUOT_W+1][LANES];
   logic [DEN_W-1:0]  rem_in  [QUOT_W+1][LANES];
   logic [QUOT_W-1:0] work_ff [QUOT_W+1][LANES];
   logic [QUOT_W-1:0] work_in [QUOT_W+1][LANES];
   logic [DEN_W-1:0]  den_ff  [QUOT_W+1][LANES];
   logic [DEN_W-1:0]  den_in  [QUOT_W+1][LANES];
   logic [LANES-1:0]  ovf_ff  [QUOT_W+1];
   logic [LANES-1:0]  ovf_in  [QUOT_W+1];
   logic [SIDE_W-1:0] side_ff [QUOT_W+1];
   logic [SIDE_W-1:0] side_in [QUOT_W+1];
   logic [QUOT_W:0]   valid_ff;
   logic [QUOT_W:0]   valid_in;

   // Flag quotients that do not fit and load the leading remainder
   for (genvar l = 0; l < LANES; l++) begin : g_entry
      logic [HEAD_W-1:0] head;
      assign head          = in_num[l][NUM_W-1 -: HEAD_W];
      assign ovf_in[0][l]  = CMP_W'(head) >= CMP_W'(in_den[l]);
      assign rem_in[0][l]  = DEN_W'(head);
      assign work_in[0][l] = in_num[l][QUOT_W-1:0];
      assign den_in[0][l]  = in_den[l];
   end
   assign valid_in[0] = in_valid;
   assign side_in[0]  = in_side;

   // One restoring step per stage
   for (genvar s = 0; s < QUOT_W; s++) begin : g_step
      for (genvar l = 0; l < LANES; l++) begin : g_lane
         logic [DEN_W:0] trial;
         logic [DEN_W:0] diff;
         logic           take;
         assign trial = {rem_ff[s][l], work_ff[s][l][QUOT_W-1]};
         assign diff  = trial - {1'b0, den_ff[s][l]};
         assign take  = trial >= {1'b0, den_ff[s][l]};
         assign rem_in[s+1][l]  = take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         assign work_in[s+1][l] = {work_ff[s][l][QUOT_W-2:0], take};
         assign den_in[s+1][l]  = den_ff[s][l];
      end
      assign ovf_in[s+1]   = ovf_ff[s];
      assign side_in[s+1]  = side_ff[s];
      assign valid_in[s+1] = valid_ff[s];
   end

   // Advance the stage registers
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      work_ff <= work_in;
      den_ff  <= den_in;
      ovf_ff  <= ovf_in;
      side_ff <= side_in;
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   for (genvar l = 0; l < LANES; l++) begin : g_out
      assign out_quot[l] = work_ff[QUOT_W][l];
   end
   assign out_ovf   = ovf_ff[QUOT_W];
   assign out_side  = side_ff[QUOT_W];
   assign out_valid = valid_ff[QUOT_W];

endmodule

`default_nettype wire
